/* src/mip_quad_downsample_macros.svh */
// ----------------------------------------------------------------------------
// Mip quad downsampler assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIP_QUAD_DOWNSAMPLE_MACROS_SVH
`define MIP_QUAD_DOWNSAMPLE_MACROS_SVH

`define MQD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define MQD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

/* src/mqd_pkg.sv */
// ----------------------------------------------------------------------------
// Mip quad downsampler package
// Types, widths and the sRGB decode and encode tables built at elaboration.
// ----------------------------------------------------------------------------
package mqd_pkg;

  typedef enum logic [1:0] {
    ModeColor  = 2'd0,
    ModeNormal = 2'd1,
    ModeLinear = 2'd2
  } mode_e;

  localparam int NumLanes  = 3;
  localparam int SumW      = 11;
  localparam int RadW      = 38;
  localparam int RootW     = 19;
  localparam int SqrtSteps = RadW / 2;
  localparam int DivSteps  = 8;
  localparam int LaneHold  = SqrtSteps + 2;
  localparam int LastStage = LaneHold + DivSteps + 2;
  localparam logic [23:0] DefaultNormal = 24'hFF8080;

  typedef logic [15:0] lin_tab_t [256];

  typedef struct packed {
    logic [7:0] srgb;
    logic [7:0] nrm;
    logic [7:0] lin;
  } lane_res_t;

  function automatic logic [63:0] pow5_q31(input logic [63:0] y);
    logic [63:0] yq;
    logic [63:0] p;
    yq = y << 15;
    p  = yq;
    for (int i = 0; i < 4; i++) begin
      p = (p * yq) >> 31;
    end
    return p;
  endfunction

  function automatic logic [15:0] lin_half(input logic [63:0] h);
    logic [63:0] t;
    logic [63:0] big;
    logic [15:0] y;
    logic [15:0] cand;
    y = '0;
    if (h <= 64'd20) begin
      return 16'((h * 64'd6553600) / 64'd658920);
    end
    t   = ((64'd1000 * h + 64'd28050) << 31) / 64'd538050;
    big = t;
    for (int i = 0; i < 11; i++) begin
      big = (big * t) >> 31;
    end
    for (int b = 15; b >= 0; b--) begin
      cand = y | (16'd1 << b);
      if (pow5_q31({48'd0, cand}) <= big) begin
        y = cand;
      end
    end
    return y;
  endfunction

  function automatic lin_tab_t gen_dec();
    lin_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = lin_half(64'(2 * i));
    end
    return tab;
  endfunction

  function automatic lin_tab_t gen_enc();
    lin_tab_t tab;
    tab[0] = '0;
    for (int i = 1; i < 256; i++) begin
      tab[i] = lin_half(64'(2 * i - 1));
    end
    return tab;
  endfunction

  localparam lin_tab_t DecTab = gen_dec();
  localparam lin_tab_t EncTab = gen_enc();

endpackage

/* src/mip_quad_downsample.sv */
// ----------------------------------------------------------------------------
// Mip quad downsampler
// Filters one 2x2 RGBA8 quad into one texel of the next mip level.
// ----------------------------------------------------------------------------
// One quad is taken on every clock and busy_o never rises. Each transaction
// returns its texel marked by mip_texel_valid_o for a single cycle, at the end
// of a pipeline set by the 19-stage square root used in normal mode and the 8
// stages of division and sRGB code search that follow it; all modes share
// the same pipeline. The user must write the filter mode through cfg_we_i and
// cfg_wdata_i only while no transaction is in flight; this is not enforced.
`include "mip_quad_downsample_macros.svh"

module mip_quad_downsample (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] texel_top_left_i,
  input  logic [31:0] texel_top_right_i,
  input  logic [31:0] texel_bottom_left_i,
  input  logic [31:0] texel_bottom_right_i,
  output logic        mip_texel_valid_o,
  output logic [31:0] mip_texel_o
);
  import mqd_pkg::*;

  typedef struct packed {
    logic       vld;
    logic [1:0] mode;
    logic [7:0] alpha;
  } stg_t;

  logic [1:0]  mode_q;
  logic [31:0] quad_q [4];
  logic [9:0]  alpha_sum;
  stg_t        stg_q [LastStage+1];
  logic signed [SumW-1:0] vec_sum [NumLanes];
  logic [19:0] sq_q [NumLanes];
  logic [21:0] sq_sum;
  logic [RadW-1:0] rad_q;
  logic        zero_q [LastStage-2];
  logic [RootW-1:0] root;
  lane_res_t   lane_res [NumLanes];
  logic [23:0] color_d;
  logic [31:0] mip_texel_q;
  logic        valid_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeLinear;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign alpha_sum = 10'(texel_top_left_i[31:24]) + 10'(texel_top_right_i[31:24]) +
                     10'(texel_bottom_left_i[31:24]) + 10'(texel_bottom_right_i[31:24]);

  always_ff @(posedge clk_i) begin
    quad_q[0] <= texel_top_left_i;
    quad_q[1] <= texel_top_right_i;
    quad_q[2] <= texel_bottom_left_i;
    quad_q[3] <= texel_bottom_right_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LastStage; i++) begin
        stg_q[i] <= '0;
      end
    end else begin
      stg_q[0].vld   <= start_i && !busy_o;
      stg_q[0].mode  <= mode_q;
      stg_q[0].alpha <= 8'((alpha_sum + 10'd2) >> 2);
      for (int i = 1; i <= LastStage; i++) begin
        stg_q[i] <= stg_q[i-1];
      end
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    logic [3:0][7:0] quad;
    logic signed [2*SumW-1:0] prod;

    always_comb begin
      for (int q = 0; q < 4; q++) begin
        quad[q] = quad_q[q][8*l +: 8];
      end
    end

    mqd_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .quad_i     (quad),
      .root_i     (root),
      .last_vld_i (stg_q[LastStage].vld),
      .vec_sum_o  (vec_sum[l]),
      .res_o      (lane_res[l])
    );

    assign prod = (2*SumW)'(vec_sum[l]) * (2*SumW)'(vec_sum[l]);

    always_ff @(posedge clk_i) begin
      sq_q[l] <= prod[19:0];
    end
  end

  assign sq_sum = 22'(sq_q[0]) + 22'(sq_q[1]) + 22'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    rad_q     <= {sq_sum, 16'd0};
    zero_q[0] <= sq_sum == '0;
    for (int i = 1; i < LastStage-2; i++) begin
      zero_q[i] <= zero_q[i-1];
    end
  end

  mqd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (rad_q),
    .root_o (root)
  );

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      case (stg_q[LastStage].mode)
        ModeColor:  color_d[8*l +: 8] = lane_res[l].srgb;
        ModeNormal: color_d[8*l +: 8] = zero_q[LastStage-3] ? DefaultNormal[8*l +: 8]
                                                           : lane_res[l].nrm;
        default:    color_d[8*l +: 8] = lane_res[l].lin;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stg_q[LastStage].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    mip_texel_q <= {stg_q[LastStage].alpha, color_d};
  end

  assign mip_texel_valid_o = valid_q;
  assign mip_texel_o       = mip_texel_q;

  `MQD_ASSERT_IMPLIES(a_out_from_start, mip_texel_valid_o, $past(start_i, LastStage+2), "Result strobe without a started transaction.")
  `MQD_ASSERT_IMPLIES(a_zero_root, stg_q[SqrtSteps+3].vld && zero_q[SqrtSteps], root == '0, "Square root of a zero vector is not zero.")
  `MQD_ASSERT_NEVER(a_never_busy, busy_o && stg_q[0].vld, "Busy raised while the pipeline is streaming.")

endmodule

/* src/mqd_sqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage.
// ----------------------------------------------------------------------------
module mqd_sqrt (
  input  logic                      clk_i,
  input  logic [mqd_pkg::RadW-1:0]  rad_i,
  output logic [mqd_pkg::RootW-1:0] root_o
);
  import mqd_pkg::*;

  typedef struct packed {
    logic [RootW+2:0] rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
  } sq_t;

  sq_t stg_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    sq_t              prev;
    sq_t              nxt;
    logic [RootW+2:0] cur;
    logic [RootW+2:0] trial;

    always_comb begin
      if (k == 0) begin
        prev = '{rem: '0, root: '0, rad: rad_i};
      end else begin
        prev = stg_q[k-1];
      end
      cur   = {prev.rem[RootW:0], prev.rad[RadW-1 -: 2]};
      trial = {1'b0, prev.root, 2'b01};
      nxt.rad = prev.rad << 2;
      if (cur >= trial) begin
        nxt.rem  = cur - trial;
        nxt.root = {prev.root[RootW-2:0], 1'b1};
      end else begin
        nxt.rem  = cur;
        nxt.root = {prev.root[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[k] <= nxt;
    end
  end

  assign root_o = stg_q[SqrtSteps-1].root;

endmodule

/* src/mqd_lane.sv */
// ----------------------------------------------------------------------------
// Mip quad downsampler channel lane
// Averages one colour channel of a quad in all three filter forms at once.
// ----------------------------------------------------------------------------
`include "mip_quad_downsample_macros.svh"

module mqd_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [3:0][7:0]                  quad_i,
  input  logic [mqd_pkg::RootW-1:0]        root_i,
  input  logic                             last_vld_i,
  output logic signed [mqd_pkg::SumW-1:0]  vec_sum_o,
  output mqd_pkg::lane_res_t               res_o
);
  import mqd_pkg::*;

  typedef struct packed {
    logic [15:0]            avg;
    logic [7:0]             lin;
    logic signed [SumW-1:0] vsum;
  } hold_t;

  typedef struct packed {
    logic [15:0]      avg;
    logic [7:0]       lin;
    logic             neg;
    logic             sat;
    logic [RootW-1:0] root;
    logic [RootW:0]   rem;
    logic [7:0]       quo;
    logic [7:0]       code;
  } div_t;

  logic [17:0] lin_sum;
  logic [9:0]  code_sum;
  hold_t       s1_d;
  hold_t       s1_q;
  hold_t       hold_q [LaneHold];
  div_t        init_d;
  div_t        init_q;
  div_t        step_q [DivSteps];
  div_t        last;
  logic signed [RootW+2:0] num;

  always_comb begin
    lin_sum  = '0;
    code_sum = '0;
    for (int q = 0; q < 4; q++) begin
      lin_sum  = lin_sum + 18'(DecTab[quad_i[q]]);
      code_sum = code_sum + 10'(quad_i[q]);
    end
    s1_d.avg  = 16'((lin_sum + 18'd2) >> 2);
    s1_d.lin  = 8'((code_sum + 10'd2) >> 2);
    s1_d.vsum = SumW'(signed'({1'b0, code_sum, 1'b0}) - 12'sd1020);
  end

  always_ff @(posedge clk_i) begin
    s1_q      <= s1_d;
    hold_q[0] <= s1_q;
    for (int i = 1; i < LaneHold; i++) begin
      hold_q[i] <= hold_q[i-1];
    end
  end

  assign vec_sum_o = s1_q.vsum;

  always_comb begin
    num = (RootW+3)'(hold_q[LaneHold-1].vsum) * 22'sd255 + signed'({3'b0, root_i});
    init_d.avg  = hold_q[LaneHold-1].avg;
    init_d.lin  = hold_q[LaneHold-1].lin;
    init_d.neg  = num < 0;
    init_d.sat  = num >= signed'({2'b0, root_i, 1'b0});
    init_d.root = root_i;
    init_d.rem  = num[RootW:0];
    init_d.quo  = '0;
    init_d.code = '0;
  end

  always_ff @(posedge clk_i) begin
    init_q <= init_d;
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    div_t           prev;
    div_t           nxt;
    logic [RootW+1:0] trial;
    logic [7:0]     cand;

    always_comb begin
      if (j == 0) begin
        prev  = init_q;
        trial = {1'b0, prev.rem};
      end else begin
        prev  = step_q[j-1];
        trial = {prev.rem, 1'b0};
      end
      nxt  = prev;
      cand = prev.code | 8'(1 << (DivSteps - 1 - j));
      if (trial >= {2'b0, prev.root}) begin
        nxt.rem = (RootW+1)'(trial - {2'b0, prev.root});
        nxt.quo[DivSteps-1-j] = 1'b1;
      end else begin
        nxt.rem = trial[RootW:0];
      end
      if (EncTab[cand] <= prev.avg) begin
        nxt.code = cand;
      end
    end

    always_ff @(posedge clk_i) begin
      step_q[j] <= nxt;
    end
  end

  assign last       = step_q[DivSteps-1];
  assign res_o.srgb = last.code;
  assign res_o.lin  = last.lin;
  assign res_o.nrm  = last.neg ? 8'h00 : (last.sat ? 8'hFF : last.quo);

  `MQD_ASSERT_NEVER(a_div_rem, last_vld_i && !last.neg && !last.sat && (last.rem >= {1'b0, last.root}), "Lane division remainder not below the root.")

endmodule
